// ----- rtl/core/sph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sph_pkg
// Shared types and constants of the sent packet history table: operation
// and status codes, the slot layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sph_pkg;

  // default slot count of the store
  localparam int DEPTH_DEF = 4096;

  // capacity clamping
  localparam int CAP_ZERO_DEFAULT = 4096;
  localparam int CAP_MIN          = 256;

  // field widths
  localparam int FUNC_W = 2;
  localparam int SEQ_W  = 16;
  localparam int WORD_W = 32;
  localparam int TIME_W = 64;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 17;

  // modulo by a capacity of at least 256 leaves a quotient below 256
  localparam int DIV_STEPS = 8;
  localparam int SHIFT_W   = 3;
  localparam int DIV_W     = SEQ_W + DIV_STEPS;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ALREADY = 2'd2;

  // one slot of the store
  typedef struct packed {
    logic [SEQ_W-1:0]  tag;
    logic [WORD_W-1:0] frame;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] size;
    logic [TIME_W-1:0] time_us;
    logic              acked;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic               load_item;
    logic               clr_start;
    logic               clr_step;
    logic               div_init;
    logic               div_step;
    logic [SHIFT_W-1:0] div_shift;
    logic               rd_en;
    logic               exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              clr_done;
    // operation of the beat on the input port
    logic [FUNC_W-1:0] in_func;
    // operation of the item in flight
    logic [FUNC_W-1:0] func;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sph_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sph_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sph_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sph_ctrl
// Sequencer of the history table: clearing sweep, slot index division,
// slot read and the final update/result step, plus the output valid.
// ----------------------------------------------------------------------------
module sph_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sph_pkg::stat_t stat,
  output sph_pkg::cmd_t      cmd
);
  import sph_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [SHIFT_W-1:0] step_r, step_nxt;
  logic               from_op_r, from_op_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    from_op_nxt = from_op_r;
    cmd         = '0;
    cmd.div_shift = step_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = from_op_r ? S_EXEC : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          if (stat.in_func == FUNC_CLEAR) begin
            cmd.clr_start = 1'b1;
            from_op_nxt   = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            cmd.div_init = 1'b1;
            step_nxt     = SHIFT_W'(DIV_STEPS - 1);
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = (stat.func == FUNC_ADD) ? S_EXEC : S_READ;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec    = 1'b1;
          from_op_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set by the result step, cleared when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      from_op_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      from_op_r   <= from_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sph_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sph_dpath
// Datapath of the history table: capacity register, item registers,
// restoring modulo unit, clearing counter, slot store and result registers.
// ----------------------------------------------------------------------------
module sph_dpath #(
  parameter int DEPTH = sph_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [sph_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic [sph_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [sph_pkg::SEQ_W-1:0]   in_seq_number,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_frame_number,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_byte_offset,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_size_bytes,
  input  wire logic [sph_pkg::TIME_W-1:0]  in_sent_time_us,
  input  wire sph_pkg::cmd_t               cmd,
  output sph_pkg::stat_t                   stat,
  output logic      [sph_pkg::STAT_W-1:0]  out_status,
  output logic      [sph_pkg::SEQ_W-1:0]   out_found_seq,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_frame,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_offset,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_size,
  output logic      [sph_pkg::TIME_W-1:0]  out_found_time_us,
  output logic                             out_found_acked
);
  import sph_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // capacity in use for a requested slot count
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] req);
    logic [CAP_W-1:0] c;
    if (req == '0) begin
      c = CAP_W'(CAP_ZERO_DEFAULT);
    end else if (req < CAP_W'(CAP_MIN)) begin
      c = CAP_W'(CAP_MIN);
    end else begin
      c = req;
    end
    if (c > CAP_W'(DEPTH)) begin
      c = CAP_W'(DEPTH);
    end
    return c;
  endfunction

  logic [CAP_W-1:0]  cap_r;
  logic [FUNC_W-1:0] func_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [WORD_W-1:0] frame_r, offset_r, size_r;
  logic [TIME_W-1:0] time_r;
  logic [SEQ_W-1:0]  rem_r, rem_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [DIV_W-1:0]  div_sub;
  logic              div_ge;
  logic [AW-1:0]     idx;
  entry_t            rd_entry, wr_entry, ack_entry;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              hit;
  entry_t            res_found;
  logic [STAT_W-1:0] res_status;

  // capacity register, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= clamp_cap('0);
    end else if (cfg_we) begin
      cap_r <= clamp_cap(cfg_data);
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r   <= in_func;
      seq_r    <= in_seq_number;
      frame_r  <= in_frame_number;
      offset_r <= in_byte_offset;
      size_r   <= in_size_bytes;
      time_r   <= in_sent_time_us;
    end
  end

  assign stat.in_func = in_func;
  assign stat.func    = func_r;

  // restoring modulo, one quotient bit a cycle from the top
  assign div_sub = DIV_W'(cap_r) << cmd.div_shift;
  assign div_ge  = DIV_W'(rem_r) >= div_sub;

  always_comb begin
    rem_nxt = rem_r;
    if (cmd.div_init) begin
      rem_nxt = in_seq_number;
    end else if (cmd.div_step && div_ge) begin
      rem_nxt = rem_r - div_sub[SEQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  // remainder is below the capacity, so it fits the index
  assign idx = rem_r[AW-1:0];

  // clearing sweep counter
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = stat.clr_done ? '0 : clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign stat.clr_done = (clr_cnt_r == AW'(DEPTH - 1));

  // slot update
  assign hit = (rd_entry.tag == seq_r);

  always_comb begin
    ack_entry       = rd_entry;
    ack_entry.acked = 1'b1;
  end

  always_comb begin
    wr_entry  = '0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (cmd.exec) begin
      if (func_r == FUNC_ADD) begin
        ram_we           = 1'b1;
        wr_entry.tag     = seq_r;
        wr_entry.frame   = frame_r;
        wr_entry.offset  = offset_r;
        wr_entry.size    = size_r;
        wr_entry.time_us = time_r;
        wr_entry.acked   = 1'b0;
      end else if (func_r == FUNC_ACK && hit && !rd_entry.acked) begin
        ram_we   = 1'b1;
        wr_entry = ack_entry;
      end
    end
  end

  sph_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rd_entry)
  );

  // result values of the item in its final step
  always_comb begin
    res_status = ST_OK;
    res_found  = '0;
    case (func_r)
      FUNC_GET: begin
        if (hit) begin
          res_found = rd_entry;
        end else begin
          res_status = ST_MISS;
        end
      end
      FUNC_ACK: begin
        if (!hit) begin
          res_status = ST_MISS;
        end else if (rd_entry.acked) begin
          res_status = ST_ALREADY;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status        <= res_status;
      out_found_seq     <= res_found.tag;
      out_found_frame   <= res_found.frame;
      out_found_offset  <= res_found.offset;
      out_found_size    <= res_found.size;
      out_found_time_us <= res_found.time_us;
      out_found_acked   <= res_found.acked;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sent_packet_history_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// get and mark acked: result valid after 8 modulo steps, one slot read and one
//   update step; add: no slot read; clear: the clearing sweep, then the update step
// input: in_stall holds off a new item until the last one has left its update
//   step, which waits while out_stall still holds the previous result
// reset: synchronous; a clearing sweep zeroes the store while in_stall stays
//   high; capacity goes to min(4096, DEPTH)
// ----------------------------------------------------------------------------
// sent_packet_history_table
// Direct-mapped table of sent packets indexed by sequence modulo capacity.
// ----------------------------------------------------------------------------
module sent_packet_history_table #(
  parameter int DEPTH = sph_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sph_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sph_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [sph_pkg::SEQ_W-1:0]   in_seq_number,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_frame_number,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_byte_offset,
  input  wire logic [sph_pkg::WORD_W-1:0]  in_size_bytes,
  input  wire logic [sph_pkg::TIME_W-1:0]  in_sent_time_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [sph_pkg::STAT_W-1:0]  out_status,
  output logic      [sph_pkg::SEQ_W-1:0]   out_found_seq,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_frame,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_offset,
  output logic      [sph_pkg::WORD_W-1:0]  out_found_size,
  output logic      [sph_pkg::TIME_W-1:0]  out_found_time_us,
  output logic                             out_found_acked
);
  import sph_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes must arrive only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  sph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sph_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_seq_number     (in_seq_number),
    .in_frame_number   (in_frame_number),
    .in_byte_offset    (in_byte_offset),
    .in_size_bytes     (in_size_bytes),
    .in_sent_time_us   (in_sent_time_us),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_found_seq     (out_found_seq),
    .out_found_frame   (out_found_frame),
    .out_found_offset  (out_found_offset),
    .out_found_size    (out_found_size),
    .out_found_time_us (out_found_time_us),
    .out_found_acked   (out_found_acked)
  );

  // result step never overwrites a beat that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // no item is taken during a clearing sweep
  a_sweep_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> in_stall)
    else $error("input open during clearing sweep");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while busy");

  // no slot read coincides with a store write by the sweep or the result step
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !(cmd.exec || cmd.clr_step))
    else $error("slot read collides with a store write");

endmodule

`default_nettype wire

// ----- verif/sent_packet_history_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sent_packet_history_table_tb
// Self-checking bench for the sent packet history table. A shadow copy of
// the slot store predicts the reply to every accepted beat. Every reply is
// checked field by field against the oldest prediction. The run starts with
// directed beats: cleared slots that match sequence 0, aliasing on the same
// slot, double acks and all-ones/all-zeros payloads. It then goes through a
// number of capacity settings with random add/get/ack/clear traffic, with
// random idle bursts on the input and random stalls on the output, save in the last.
// ----------------------------------------------------------------------------
module sent_packet_history_table_tb;
  import sph_pkg::*;

  localparam int ITEMS_PER_PHASE = 100;
  localparam int MAX_REPORTS     = 10;

  // one input beat
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] frame;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] size;
    logic [TIME_W-1:0] time_us;
  } pkt_item_t;

  // one reply beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    entry_t            found;
  } reply_t;

  // shadow of the slot store and the queue of replies it predicts
  class history_shadow;
    entry_t           slots [DEPTH_DEF];
    logic [CAP_W-1:0] cap_req;
    reply_t           pending_replies [$];
    int               errors;
    int               replies_seen;
    int               func_count [4];

    function new();
      clear_slots();
      cap_req      = '0;
      errors       = 0;
      replies_seen = 0;
      foreach (func_count[i]) func_count[i] = 0;
    endfunction

    function void clear_slots();
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // slot count derived from the requested capacity
    function int capacity_now();
      int c;
      c = int'(cap_req);
      if (c == 0) c = CAP_ZERO_DEFAULT;
      else if (c < CAP_MIN) c = CAP_MIN;
      if (c > DEPTH_DEF) c = DEPTH_DEF;
      return c;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap_req = v;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // apply one accepted beat and queue the reply it must produce
    function void note_item(pkt_item_t it);
      reply_t r;
      int     idx;
      r   = '0;
      idx = int'(it.seq) % capacity_now();
      func_count[it.func]++;
      case (it.func)
        FUNC_ADD: begin
          slots[idx].tag     = it.seq;
          slots[idx].frame   = it.frame;
          slots[idx].offset  = it.offset;
          slots[idx].size    = it.size;
          slots[idx].time_us = it.time_us;
          slots[idx].acked   = 1'b0;
          r.status = ST_OK;
        end
        FUNC_GET: begin
          if (slots[idx].tag != it.seq) begin
            r.status = ST_MISS;
          end else begin
            r.status = ST_OK;
            r.found  = slots[idx];
          end
        end
        FUNC_ACK: begin
          if (slots[idx].tag != it.seq) begin
            r.status = ST_MISS;
          end else if (slots[idx].acked) begin
            r.status = ST_ALREADY;
          end else begin
            slots[idx].acked = 1'b1;
            r.status = ST_OK;
          end
        end
        default: begin
          clear_slots();
          r.status = ST_OK;
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    // compare one accepted reply with the oldest prediction
    function void check_reply(reply_t got);
      reply_t exp;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] reply %0d arrived with nothing predicted (status %0d)",
                   $realtime, replies_seen, got.status);
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status        !== exp.status        ||
          got.found.tag     !== exp.found.tag     ||
          got.found.frame   !== exp.found.frame   ||
          got.found.offset  !== exp.found.offset  ||
          got.found.size    !== exp.found.size    ||
          got.found.time_us !== exp.found.time_us ||
          got.found.acked   !== exp.found.acked) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] reply %0d exp: st %0d seq %h frm %h off %h sz %h t %h ack %b",
                   $realtime, replies_seen, exp.status, exp.found.tag, exp.found.frame,
                   exp.found.offset, exp.found.size, exp.found.time_us, exp.found.acked);
          $display("[%0t] reply %0d got: st %0d seq %h frm %h off %h sz %h t %h ack %b",
                   $realtime, replies_seen, got.status, got.found.tag, got.found.frame,
                   got.found.offset, got.found.size, got.found.time_us, got.found.acked);
        end
      end
    endfunction
  endclass

  // block inputs, known from time zero
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_valid       = 1'b0;
  logic [CAP_W-1:0]  cfg_data        = '0;
  logic              in_valid        = 1'b0;
  logic [FUNC_W-1:0] in_func         = FUNC_GET;
  logic [SEQ_W-1:0]  in_seq_number   = '0;
  logic [WORD_W-1:0] in_frame_number = '0;
  logic [WORD_W-1:0] in_byte_offset  = '0;
  logic [WORD_W-1:0] in_size_bytes   = '0;
  logic [TIME_W-1:0] in_sent_time_us = '0;
  logic              out_stall       = 1'b0;

  // block outputs
  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [SEQ_W-1:0]  out_found_seq;
  logic [WORD_W-1:0] out_found_frame;
  logic [WORD_W-1:0] out_found_offset;
  logic [WORD_W-1:0] out_found_size;
  logic [TIME_W-1:0] out_found_time_us;
  logic              out_found_acked;

  history_shadow shadow;
  bit            quiet = 1'b0;
  int            stall_hold = 0;
  int            settings_run = 1;
  int            cap_plan [11];
  logic [SEQ_W-1:0] recent_seqs [$];

  sent_packet_history_table #(
    .DEPTH(DEPTH_DEF)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_seq_number     (in_seq_number),
    .in_frame_number   (in_frame_number),
    .in_byte_offset    (in_byte_offset),
    .in_size_bytes     (in_size_bytes),
    .in_sent_time_us   (in_sent_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_seq     (out_found_seq),
    .out_found_frame   (out_found_frame),
    .out_found_offset  (out_found_offset),
    .out_found_size    (out_found_size),
    .out_found_time_us (out_found_time_us),
    .out_found_acked   (out_found_acked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stall bursts, none when quiet
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 17);
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 30);
    end
  end

  // collect every accepted reply beat
  always @(posedge clk) begin : watch_replies
    reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status        = out_status;
      got.found.tag     = out_found_seq;
      got.found.frame   = out_found_frame;
      got.found.offset  = out_found_offset;
      got.found.size    = out_found_size;
      got.found.time_us = out_found_time_us;
      got.found.acked   = out_found_acked;
      shadow.check_reply(got);
    end
  end

  function automatic pkt_item_t mk(logic [FUNC_W-1:0] f, logic [SEQ_W-1:0] s,
                                   logic [WORD_W-1:0] w, logic [TIME_W-1:0] t);
    pkt_item_t it;
    it.func    = f;
    it.seq     = s;
    it.frame   = w;
    it.offset  = ~w;
    it.size    = {w[15:0], w[31:16]};
    it.time_us = t;
    return it;
  endfunction

  // sequence choice: lookups mostly use recent adds and their aliases, adds mostly random
  function automatic logic [SEQ_W-1:0] pick_seq(logic [FUNC_W-1:0] f);
    int r;
    logic [SEQ_W-1:0] base;
    r = $urandom_range(0, 99);
    if (recent_seqs.size() == 0) return SEQ_W'($urandom);
    base = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
    if (f == FUNC_ADD) begin
      if (r < 60) return SEQ_W'($urandom);
      if (r < 80) return base + SEQ_W'(shadow.capacity_now());
      return SEQ_W'($urandom_range(0, 15));
    end
    if (r < 75) return base;
    if (r < 85) return base + SEQ_W'(shadow.capacity_now());
    if (r < 95) return SEQ_W'($urandom);
    return '0;
  endfunction

  function automatic pkt_item_t random_item();
    pkt_item_t it;
    int r;
    it.frame   = $urandom;
    it.offset  = $urandom;
    it.size    = $urandom;
    it.time_us = {$urandom, $urandom};
    r = $urandom_range(0, 999);
    if (r < 4) it.func = FUNC_CLEAR;
    else if (r < 360) it.func = FUNC_ADD;
    else if (r < 680) it.func = FUNC_GET;
    else it.func = FUNC_ACK;
    it.seq = pick_seq(it.func);
    if (it.func == FUNC_ADD) begin
      recent_seqs.push_back(it.seq);
      if (recent_seqs.size() > 24) void'(recent_seqs.pop_front());
    end
    return it;
  endfunction

  // drive one input beat, with an optional idle burst ahead of it
  task automatic send_item(input pkt_item_t it);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= it.func;
    in_seq_number   <= it.seq;
    in_frame_number <= it.frame;
    in_byte_offset  <= it.offset;
    in_size_bytes   <= it.size;
    in_sent_time_us <= it.time_us;
    do @(posedge clk); while (in_stall);
    shadow.note_item(it);
  endtask

  // drop valid and wait until every predicted reply has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(random_item());
  endtask

  // directed beats at the reset capacity
  task automatic run_directed();
    pkt_item_t seq_list [$];
    seq_list.push_back(mk(FUNC_GET,   16'h0000, 32'h0, 64'h0));  // cleared slot hit
    seq_list.push_back(mk(FUNC_ACK,   16'h0000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ACK,   16'h0000, 32'h0, 64'h0));  // double ack
    seq_list.push_back(mk(FUNC_GET,   16'h0000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_GET,   16'h1000, 32'h0, 64'h0));  // alias of slot 0
    seq_list.push_back(mk(FUNC_ACK,   16'h1000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ADD,   16'hFFFF, 32'hFFFF_FFFF, '1));
    seq_list.push_back(mk(FUNC_GET,   16'hFFFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ACK,   16'hFFFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ACK,   16'hFFFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_GET,   16'hFFFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ADD,   16'h0FFF, 32'h0, 64'h0));  // overwrites top slot
    seq_list.push_back(mk(FUNC_GET,   16'hFFFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_GET,   16'h0FFF, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ADD,   16'h0001, 32'hA5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5));
    seq_list.push_back(mk(FUNC_GET,   16'h0001, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ACK,   16'h0005, 32'h0, 64'h0));  // never written
    seq_list.push_back(mk(FUNC_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, '1));
    seq_list.push_back(mk(FUNC_GET,   16'h0001, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_GET,   16'h0000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ADD,   16'h1000, 32'h5A5A_5A5A, 64'h5A5A_5A5A_5A5A_5A5A));
    seq_list.push_back(mk(FUNC_GET,   16'h1000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_GET,   16'h0000, 32'h0, 64'h0));
    seq_list.push_back(mk(FUNC_ACK,   16'h0000, 32'h0, 64'h0));
    foreach (seq_list[i]) send_item(seq_list[i]);
  endtask

  // main sequence: reset, directed beats and a random phase, then one random phase per setting
  initial begin
    shadow = new();
    cap_plan = '{256, 1, 1000, 'h1FFFF, 255, 4097, 65536, 4095, 0, 0, 4096};
    cap_plan[8] = $urandom_range(257, 4095);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(ITEMS_PER_PHASE);
    foreach (cap_plan[p]) begin
      wait_drained();
      if (p == $size(cap_plan) - 1) quiet = 1'b1;
      write_capacity(CAP_W'(cap_plan[p]));
      run_random(ITEMS_PER_PHASE);
    end

    // let the last replies and any stray beat come out
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d beats: add %0d, get %0d, ack %0d, clear %0d, over %0d capacities",
             shadow.func_count[FUNC_ADD] + shadow.func_count[FUNC_GET] +
             shadow.func_count[FUNC_ACK] + shadow.func_count[FUNC_CLEAR],
             shadow.func_count[FUNC_ADD], shadow.func_count[FUNC_GET],
             shadow.func_count[FUNC_ACK], shadow.func_count[FUNC_CLEAR], settings_run);
    $display("%0d replies checked, %0d bad, %0d still outstanding",
             shadow.replies_seen, shadow.errors, shadow.pending());
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
